// ===== design/dpni_pkg.sv =====
`default_nettype none

package dpni_pkg;

   // geometry of the line store
   localparam int MAX_WIDTH   = 2048;
   localparam int LINE_STORES = 4;
   localparam int HIST_DEPTH  = LINE_STORES * MAX_WIDTH + 8;
   localparam int ADDR_W      = $clog2(HIST_DEPTH);

   // field widths
   localparam int PIX_W    = 16;
   localparam int WIDTH_W  = 12;
   localparam int HEIGHT_W = 16;
   localparam int COL_W    = $clog2(MAX_WIDTH);

   // pending count and signed neighbor distance
   localparam int PEND_W = $clog2(2 * MAX_WIDTH + 4);
   localparam int DIST_W = $clog2(2 * MAX_WIDTH + 3) + 1;

   // register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MOSAIC_MODE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_PHASE  = 2'd3;

   // input commands
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

endpackage

`default_nettype wire

// ===== design/defect_pixel_neighbor_interpolator_top.sv =====
`default_nettype none

// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-----------------------------------------
// req      | in        | req_valid/req_ready  | req_command, req_pixel_value, req_pixel_bad
// rsp      | out       | rsp_valid/rsp_ready  | rsp_out_value, rsp_was_replaced, rsp_frame_last
// csr      | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// a pixel transfer that produces no output is accepted and leaves req open; a transfer
// that produces an output (pixel past the two-line lag, or a drain with pixels pending)
// runs from the accept through the ST_READ line store lookups (center plus four neighbors
// through its single read port) to ST_FINISH, which averages and loads the output register
// reset clears neither line store nor payload registers; the others return to their defaults
// a stalled rsp holds the block in ST_FINISH until the output register frees up

module defect_pixel_neighbor_interpolator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [dpni_pkg::PIX_W-1:0]        req_pixel_value,
   input  logic                              req_pixel_bad,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dpni_pkg::PIX_W-1:0]        rsp_out_value,
   output logic                              rsp_was_replaced,
   output logic                              rsp_frame_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dpni_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dpni_pkg::CSR_DATA_W-1:0]   csr_data
);
   import dpni_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // lookup steps: step 0 reads the center, steps 1 to 4 the neighbors
   localparam int         STEP_W      = 3;
   localparam logic [2:0] STEP_FIRST  = 3'd0;
   localparam logic [2:0] STEP_CENTER = 3'd1;
   localparam logic [2:0] STEP_LAST   = 3'd5;

   // neighbor patterns
   localparam logic [1:0] SET_MONO = 2'd0;
   localparam logic [1:0] SET_DIAG = 2'd1;
   localparam logic [1:0] SET_FAR  = 2'd2;

   localparam int MEM_W  = PIX_W + 1;
   localparam int SUM_W  = PIX_W + 2;
   localparam int CNT_W  = 3;
   localparam int LIM_W  = WIDTH_W + 2;
   localparam int NR_W   = HEIGHT_W + 1;
   localparam int NC_W   = WIDTH_W + 1;
   localparam int SADR_W = ADDR_W + 2;

   // divide by three as multiply by reciprocal, exact for any sum below 2**SUM_W
   localparam int              RECIP_SHIFT = SUM_W + 1;
   localparam logic [SUM_W-1:0] RECIP3     = SUM_W'((2 ** RECIP_SHIFT + 2) / 3);

   localparam logic [WIDTH_W-1:0] WIDTH_MAX = WIDTH_W'(MAX_WIDTH);
   localparam logic [ADDR_W-1:0]  PTR_LAST  = ADDR_W'(HIST_DEPTH - 1);

   function automatic logic [ADDR_W-1:0] ptr_next(input logic [ADDR_W-1:0] p);
      ptr_next = (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   // configuration registers
   logic [WIDTH_W-1:0]  frame_width_ff;
   logic [HEIGHT_W-1:0] frame_height_ff;
   logic                mosaic_mode_ff;
   logic                green_phase_ff;

   // control state
   logic [1:0]          state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [ADDR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PEND_W-1:0]   pending_ff, pending_in;
   logic [COL_W-1:0]    out_col_ff, out_col_in;
   logic [HEIGHT_W-1:0] out_row_ff, out_row_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // working registers
   logic                use_ff, use_in;
   logic [PIX_W-1:0]    ctr_val_ff, ctr_val_in;
   logic                ctr_bad_ff, ctr_bad_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PIX_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                rsp_replaced_ff, rsp_replaced_in;
   logic                rsp_last_ff, rsp_last_in;

   // line store: history ring of value and bad flag
   logic [MEM_W-1:0]    line_store_mem [HIST_DEPTH];
   logic [MEM_W-1:0]    rd_word_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                mem_we;

   logic                req_fire;
   logic [WIDTH_W-1:0]  eff_w;
   logic [HEIGHT_W-1:0] eff_h;
   logic [PEND_W-1:0]   pend_inc;
   logic [LIM_W-1:0]    lag_limit;
   logic                lag_full;
   logic                col_end, row_end;

   // neighbor address generation
   logic [1:0]               nbr_set;
   logic [1:0]               nbr_k;
   logic signed [2:0]        nbr_mag, dr, dc;
   logic signed [DIST_W-1:0] w_s, row_off, nbr_dist;
   logic signed [SADR_W-1:0] sum_addr, wrap_addr;
   logic signed [NR_W-1:0]   nr;
   logic signed [NC_W-1:0]   nc;
   logic                     nbr_ok;

   // averaging
   logic [2*SUM_W-1:0]  prod3;
   logic [PIX_W-1:0]    mean;
   logic                replace;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign mem_we    = req_fire && (req_command == CMD_PIXEL);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_was_replaced = rsp_replaced_ff;
   assign rsp_frame_last   = rsp_last_ff;

   // effective geometry: width clamped to 1..max, height zero acts as one
   always_comb begin
      if (frame_width_ff == '0) begin
         eff_w = WIDTH_W'(1);
      end else if (frame_width_ff > WIDTH_MAX) begin
         eff_w = WIDTH_MAX;
      end else begin
         eff_w = frame_width_ff;
      end
      eff_h = (frame_height_ff == '0) ? HEIGHT_W'(1) : frame_height_ff;
   end

   // lag of two lines and two pixels
   assign pend_inc  = pending_ff + 1'b1;
   assign lag_limit = LIM_W'({eff_w, 1'b0}) + LIM_W'(2);
   assign lag_full  = LIM_W'(pend_inc) > lag_limit;

   // output position at line and frame end
   assign col_end = ({1'b0, out_col_ff} + 1'b1) >= eff_w;
   assign row_end = ({1'b0, out_row_ff} + 1'b1) >= {1'b0, eff_h};

   // pattern choice: mono, or diagonal on green sites and distance two on red and blue
   always_comb begin
      if (!mosaic_mode_ff) begin
         nbr_set = SET_MONO;
      end else if ((out_row_ff[0] ^ out_col_ff[0]) == green_phase_ff) begin
         nbr_set = SET_DIAG;
      end else begin
         nbr_set = SET_FAR;
      end
   end

   assign nbr_k   = 2'(step_ff - STEP_CENTER);
   assign nbr_mag = (nbr_set == SET_FAR) ? 3'sd2 : 3'sd1;

   always_comb begin
      dr = '0;
      dc = '0;
      if (nbr_set == SET_DIAG) begin
         dr = nbr_k[1] ? 3'sd1 : -3'sd1;
         dc = nbr_k[0] ? 3'sd1 : -3'sd1;
      end else begin
         case (nbr_k)
            2'd0:    dc = -nbr_mag;
            2'd1:    dc = nbr_mag;
            2'd2:    dr = -nbr_mag;
            default: dr = nbr_mag;
         endcase
      end
   end

   // raster distance from the center to the neighbor
   assign w_s = DIST_W'(eff_w);

   always_comb begin
      case (dr)
         -3'sd2:  row_off = -(w_s <<< 1);
         -3'sd1:  row_off = -w_s;
         3'sd1:   row_off = w_s;
         3'sd2:   row_off = w_s <<< 1;
         default: row_off = '0;
      endcase
   end

   assign nbr_dist = row_off + DIST_W'(dc);

   // ring address of the neighbor
   assign sum_addr = $signed(SADR_W'(rd_ptr_ff)) + SADR_W'(nbr_dist);

   always_comb begin
      if (sum_addr < 0) begin
         wrap_addr = sum_addr + SADR_W'(HIST_DEPTH);
      end else if (sum_addr >= SADR_W'(HIST_DEPTH)) begin
         wrap_addr = sum_addr - SADR_W'(HIST_DEPTH);
      end else begin
         wrap_addr = sum_addr;
      end
   end

   assign rd_addr = (step_ff == STEP_FIRST) ? rd_ptr_ff : wrap_addr[ADDR_W-1:0];

   // usable: inside the frame and already received
   assign nr = $signed(NR_W'(out_row_ff)) + NR_W'(dr);
   assign nc = $signed(NC_W'(out_col_ff)) + NC_W'(dc);

   assign nbr_ok = (nr >= 0) && (nr < $signed(NR_W'(eff_h)))
                && (nc >= 0) && (nc < $signed(NC_W'(eff_w)))
                && (nbr_dist < $signed(DIST_W'(pending_ff)));

   // truncated mean over one to four neighbors
   assign prod3 = sum_ff * RECIP3;

   always_comb begin
      case (cnt_ff)
         3'd1:    mean = sum_ff[PIX_W-1:0];
         3'd2:    mean = sum_ff[PIX_W:1];
         3'd3:    mean = prod3[RECIP_SHIFT +: PIX_W];
         3'd4:    mean = sum_ff[PIX_W+1:2];
         default: mean = ctr_val_ff;
      endcase
   end

   // a bad pixel with no usable neighbor keeps its own value
   assign replace = ctr_bad_ff && (cnt_ff != '0);

   // sequencer
   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      wr_ptr_in       = wr_ptr_ff;
      rd_ptr_in       = rd_ptr_ff;
      pending_in      = pending_ff;
      out_col_in      = out_col_ff;
      out_row_in      = out_row_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      use_in          = nbr_ok;
      ctr_val_in      = ctr_val_ff;
      ctr_bad_in      = ctr_bad_ff;
      sum_in          = sum_ff;
      cnt_in          = cnt_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_replaced_in = rsp_replaced_ff;
      rsp_last_in     = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_command == CMD_PIXEL) begin
                  wr_ptr_in  = ptr_next(wr_ptr_ff);
                  pending_in = pend_inc;
                  if (lag_full) begin
                     state_in = ST_READ;
                     step_in  = STEP_FIRST;
                  end
               end else if (pending_ff != '0) begin
                  // drain of the oldest pending pixel
                  state_in = ST_READ;
                  step_in  = STEP_FIRST;
               end
            end
         end
         ST_READ: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_FINISH;
            end
            // read data trails the address by one step
            if (step_ff == STEP_CENTER) begin
               ctr_val_in = rd_word_ff[PIX_W-1:0];
               ctr_bad_in = rd_word_ff[PIX_W];
               sum_in     = '0;
               cnt_in     = '0;
            end else if (step_ff != STEP_FIRST && use_ff && !rd_word_ff[PIX_W]) begin
               sum_in = sum_ff + SUM_W'(rd_word_ff[PIX_W-1:0]);
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_value_in    = replace ? mean : ctr_val_ff;
               rsp_replaced_in = replace;
               rsp_last_in     = col_end && row_end;
               rd_ptr_in       = ptr_next(rd_ptr_ff);
               pending_in      = pending_ff - 1'b1;
               state_in        = ST_IDLE;
               // raster advance of the output position
               if (col_end) begin
                  out_col_in = '0;
                  out_row_in = row_end ? '0 : out_row_ff + 1'b1;
               end else begin
                  out_col_in = out_col_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_FIRST;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         pending_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         pending_ff   <= pending_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_MAX;
         frame_height_ff <= HEIGHT_W'(1024);
         mosaic_mode_ff  <= 1'b0;
         green_phase_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[HEIGHT_W-1:0];
            CSR_MOSAIC_MODE:  mosaic_mode_ff  <= csr_data[0];
            CSR_GREEN_PHASE:  green_phase_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      use_ff          <= use_in;
      ctr_val_ff      <= ctr_val_in;
      ctr_bad_ff      <= ctr_bad_in;
      sum_ff          <= sum_in;
      cnt_ff          <= cnt_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_replaced_ff <= rsp_replaced_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // line store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store_mem[wr_ptr_ff] <= {req_pixel_bad, req_pixel_value};
      end
      rd_word_ff <= line_store_mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/dpni_checker.sv =====
`default_nettype none

module dpni_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [dpni_pkg::PIX_W-1:0]        rsp_out_value,
   input logic                              rsp_was_replaced,
   input logic                              rsp_frame_last
);

   // output register empties on reset
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a new result only after the lookup sequence kept req closed
   a_rsp_after_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready) && !$past(req_ready, 2)
                           && !$past(req_ready, 7))
      else $error("result appeared without a full lookup sequence");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_value)
                                  && $stable(rsp_was_replaced) && $stable(rsp_frame_last))
      else $error("stalled result changed");

endmodule

bind defect_pixel_neighbor_interpolator_top dpni_checker u_dpni_checker (.*);

`default_nettype wire
